### hw/rtl/rdwr_pkg.sv
// shared types and constants of the random draw without replacement block
`default_nettype none

package rdwr_pkg;

  // table geometry
  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned RND_W      = 31;

  // largest usable pool size
  localparam int unsigned SIZE_TOP_INT = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
  localparam logic [CNT_W-1:0] SIZE_TOP = CNT_W'(SIZE_TOP_INT);
  localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(1);

  // serial remainder unit: one dividend bit per step
  localparam int unsigned DIV_STEPS = RND_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // request codes
  typedef enum logic [1:0] {
    REQ_DRAW    = 2'd0,
    REQ_CANCEL  = 2'd1,
    REQ_RESTART = 2'd2
  } rdwr_req_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RD_SLOT,
    ST_RD_LAST,
    ST_WR_SLOT,
    ST_WR_LAST,
    ST_DONE
  } rdwr_state_e;

  // input beat
  typedef struct packed {
    logic [1:0]       req_type;
    logic [RND_W-1:0] random_word;
  } rdwr_in_t;

  // output beat
  typedef struct packed {
    logic [VAL_W-1:0] drawn_value;
    logic             pool_empty;
    logic [CNT_W-1:0] remaining;
  } rdwr_out_t;

  // remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } rdwr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } rdwr_div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/rdwr_div.sv
// serial restoring remainder unit: random word modulo live count
`default_nettype none

module rdwr_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rdwr_pkg::rdwr_div_req_t req_i,
  output rdwr_pkg::rdwr_div_rsp_t      rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [rdwr_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [rdwr_pkg::RND_W-1:0]          dvd_q, dvd_d;
  logic [rdwr_pkg::CNT_W-1:0]          dsr_q, dsr_d;
  logic [rdwr_pkg::CNT_W-1:0]          rem_q, rem_d;
  logic [rdwr_pkg::CNT_W:0]            trial;
  logic [rdwr_pkg::CNT_W:0]            dsr_ext;

  // one shift, compare and subtract step per cycle
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    dsr_ext = {1'b0, dsr_q};
    trial   = {rem_q, dvd_q[rdwr_pkg::RND_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= dsr_ext) begin
        rem_d = rdwr_pkg::CNT_W'(trial - dsr_ext);
      end else begin
        rem_d = trial[rdwr_pkg::CNT_W-1:0];
      end
      dvd_d = {dvd_q[rdwr_pkg::RND_W-2:0], 1'b0};
      cnt_d = cnt_q + rdwr_pkg::DIV_CNT_W'(1);
      if (cnt_q == rdwr_pkg::DIV_CNT_W'(rdwr_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  // remainder is below the divisor, so it fits a table index
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[rdwr_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/random_draw_without_replacement.sv
// top level: random draw without replacement over a swap table
//
// Usage: each input beat carries req_type and random_word. A draw reduces
// random_word modulo the live count in a serial remainder unit (one bit per
// cycle), reads the picked slot and the last live slot from the table
// memory, then writes the swapped pair back, picked slot first. Cancel,
// restart, an unknown request and a draw on an empty pool skip these steps.
// The next input beat is taken only once the result has been loaded into
// the output register. The remainder unit and the single table port set
// the draw timing. One item is in work at a time;
// in_stall_o is high while an item is in work.
// Every request gives exactly one output beat. The result sits in an output
// register; while out_stall_i holds it, the next item is still accepted and
// worked, and its result waits until the register frees up.
// pool_size is written through cfg_we_i / cfg_wdata_i and becomes active
// only on a restart request. After reset the pool size is 256, the table
// holds the identity permutation (per-entry valid bits, no clearing pass)
// and all values remain. A restart refills the identity by clearing the valid bits.
`default_nettype none

module random_draw_without_replacement (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rdwr_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire rdwr_pkg::rdwr_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output rdwr_pkg::rdwr_out_t              out_data_o
);

  rdwr_pkg::rdwr_state_e              state_q, state_d;
  logic [rdwr_pkg::CNT_W-1:0]         pool_size_q;
  logic [rdwr_pkg::CNT_W-1:0]         active_q, active_d;
  logic [rdwr_pkg::CNT_W-1:0]         live_q, live_d;
  logic [rdwr_pkg::CNT_W-1:0]         live_m1;
  logic [rdwr_pkg::CNT_W-1:0]         size_n;
  logic [rdwr_pkg::POOL_DEPTH-1:0]    vld_q;
  logic                               vld_clr;
  logic                               mem_we;
  logic [rdwr_pkg::IDX_W-1:0]         mem_wa;
  logic [rdwr_pkg::VAL_W-1:0]         mem_wd;
  logic [rdwr_pkg::IDX_W-1:0]         mem_ra;
  logic [rdwr_pkg::VAL_W-1:0]         mem_q [rdwr_pkg::POOL_DEPTH];
  logic [rdwr_pkg::VAL_W-1:0]         rd_q;
  logic                               rd_vld_q;
  logic [rdwr_pkg::IDX_W-1:0]         slot_q, slot_d;
  logic [rdwr_pkg::IDX_W-1:0]         last_q, last_d;
  logic [rdwr_pkg::VAL_W-1:0]         picked_q, picked_d;
  rdwr_pkg::rdwr_out_t                res_q, res_d;
  rdwr_pkg::rdwr_out_t                out_q;
  logic                               out_vld_q, out_vld_d;
  logic                               out_load;
  logic                               in_acc;
  rdwr_pkg::rdwr_div_req_t            div_req;
  rdwr_pkg::rdwr_div_rsp_t            div_rsp;

  // serial remainder unit
  rdwr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // handshake and helpers
  assign in_stall_o = (state_q != rdwr_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == rdwr_pkg::ST_IDLE);
  assign out_load   = (state_q == rdwr_pkg::ST_DONE) && (!out_vld_q || !out_stall_i);
  assign out_vld_d  = out_load || (out_vld_q && out_stall_i);
  assign live_m1    = live_q - rdwr_pkg::CNT_W'(1);

  // clamp the requested pool size
  always_comb begin
    if (pool_size_q < rdwr_pkg::SIZE_MIN) begin
      size_n = rdwr_pkg::SIZE_MIN;
    end else if (pool_size_q > rdwr_pkg::SIZE_TOP) begin
      size_n = rdwr_pkg::SIZE_TOP;
    end else begin
      size_n = pool_size_q;
    end
  end

  // sequencer: next state, datapath controls
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    live_d   = live_q;
    vld_clr  = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = slot_q;
    mem_wd   = picked_q;
    mem_ra   = slot_q;
    slot_d   = slot_q;
    last_d   = last_q;
    picked_d = picked_q;
    res_d    = res_q;
    div_req  = '0;
    unique case (state_q)
      rdwr_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          state_d = rdwr_pkg::ST_DONE;
          case (in_data_i.req_type)
            rdwr_pkg::REQ_DRAW: begin
              if (live_q == '0) begin
                res_d.pool_empty = 1'b1;
                res_d.remaining  = live_q;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = in_data_i.random_word;
                div_req.divisor  = live_q;
                state_d          = rdwr_pkg::ST_DIVIDE;
              end
            end
            rdwr_pkg::REQ_CANCEL: begin
              if (live_q < active_q) begin
                live_d = live_q + rdwr_pkg::CNT_W'(1);
              end
              res_d.remaining = live_d;
            end
            rdwr_pkg::REQ_RESTART: begin
              active_d        = size_n;
              live_d          = size_n;
              vld_clr         = 1'b1;
              res_d.remaining = size_n;
            end
            default: begin
              res_d.remaining = live_q;
            end
          endcase
        end
      end
      rdwr_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          slot_d  = div_rsp.rem;
          last_d  = live_m1[rdwr_pkg::IDX_W-1:0];
          state_d = rdwr_pkg::ST_RD_SLOT;
        end
      end
      rdwr_pkg::ST_RD_SLOT: begin
        mem_ra  = slot_q;
        state_d = rdwr_pkg::ST_RD_LAST;
      end
      rdwr_pkg::ST_RD_LAST: begin
        mem_ra   = last_q;
        picked_d = rd_vld_q ? rd_q : rdwr_pkg::VAL_W'(slot_q);
        state_d  = rdwr_pkg::ST_WR_SLOT;
      end
      rdwr_pkg::ST_WR_SLOT: begin
        mem_we  = 1'b1;
        mem_wa  = slot_q;
        mem_wd  = rd_vld_q ? rd_q : rdwr_pkg::VAL_W'(last_q);
        state_d = rdwr_pkg::ST_WR_LAST;
      end
      rdwr_pkg::ST_WR_LAST: begin
        mem_we            = 1'b1;
        mem_wa            = last_q;
        mem_wd            = picked_q;
        live_d            = live_m1;
        res_d.drawn_value = picked_q;
        res_d.pool_empty  = 1'b0;
        res_d.remaining   = live_m1;
        state_d           = rdwr_pkg::ST_DONE;
      end
      rdwr_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = rdwr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rdwr_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdwr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pool size register, counts and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= rdwr_pkg::CNT_W'(256);
      active_q    <= rdwr_pkg::SIZE_TOP;
      live_q      <= rdwr_pkg::SIZE_TOP;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_size_q <= cfg_wdata_i;
      end
      active_q  <= active_d;
      live_q    <= live_d;
      out_vld_q <= out_vld_d;
    end
  end

  // per-entry written flags, cleared by reset and restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (vld_clr) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[mem_wa] <= 1'b1;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q     <= mem_q[mem_ra];
    rd_vld_q <= vld_q[mem_ra];
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    last_q   <= last_d;
    picked_q <= picked_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### bench/random_draw_without_replacement_tb.sv
// testbench of the random draw without replacement block: pool model, random and directed beats
`timescale 1ns / 1ps

module random_draw_without_replacement_tb;

  // request code that the block ignores
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rdwr_pkg::CNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  rdwr_pkg::rdwr_in_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rdwr_pkg::rdwr_out_t out_beat;

  // pool model state
  logic [rdwr_pkg::VAL_W-1:0] perm_tbl [rdwr_pkg::POOL_DEPTH];
  logic [rdwr_pkg::CNT_W-1:0] live_cnt;
  logic [rdwr_pkg::CNT_W-1:0] active_n;
  logic [rdwr_pkg::CNT_W-1:0] pool_reg;

  rdwr_pkg::rdwr_in_t pending_req_q [$];
  rdwr_pkg::rdwr_out_t owed_outcome_q [$];
  int unsigned fault_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  random_draw_without_replacement dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat)
  );

  always #2 clk = ~clk;

  // clamp the register value into the usable pool sizes
  function automatic logic [rdwr_pkg::CNT_W-1:0] clamp_pool(logic [rdwr_pkg::CNT_W-1:0] v);
    if (v < rdwr_pkg::SIZE_MIN) return rdwr_pkg::SIZE_MIN;
    if (v > rdwr_pkg::SIZE_TOP) return rdwr_pkg::SIZE_TOP;
    return v;
  endfunction

  // identity permutation and full pool
  function automatic void refill_pool();
    for (int i = 0; i < rdwr_pkg::POOL_DEPTH; i++) perm_tbl[i] = rdwr_pkg::VAL_W'(i);
    active_n = clamp_pool(pool_reg);
    live_cnt = active_n;
  endfunction

  // apply one request to the pool model and return its outcome
  function automatic rdwr_pkg::rdwr_out_t draw_outcome(rdwr_pkg::rdwr_in_t beat);
    rdwr_pkg::rdwr_out_t res;
    logic [rdwr_pkg::CNT_W-1:0] slot;
    logic [rdwr_pkg::CNT_W-1:0] last;
    logic [rdwr_pkg::VAL_W-1:0] picked;
    res = '0;
    case (beat.req_type)
      rdwr_pkg::REQ_DRAW: begin
        if (live_cnt == 0) begin
          res.pool_empty = 1'b1;
        end else begin
          slot = rdwr_pkg::CNT_W'(beat.random_word % live_cnt);
          last = live_cnt - 1'b1;
          picked = perm_tbl[slot];
          perm_tbl[slot] = perm_tbl[last];
          perm_tbl[last] = picked;
          live_cnt = last;
          res.drawn_value = picked;
        end
      end
      rdwr_pkg::REQ_CANCEL: begin
        if (live_cnt < active_n) live_cnt = live_cnt + 1'b1;
      end
      rdwr_pkg::REQ_RESTART: refill_pool();
      default: ;
    endcase
    res.remaining = live_cnt;
    return res;
  endfunction

  task automatic flag_fault(string msg);
    fault_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // random word biased toward the extremes and small values
  function automatic logic [rdwr_pkg::RND_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 30) return rdwr_pkg::RND_W'($urandom_range(511));
    return rdwr_pkg::RND_W'($urandom);
  endfunction

  task automatic add_req(logic [1:0] kind, logic [rdwr_pkg::RND_W-1:0] word);
    rdwr_pkg::rdwr_in_t b;
    b.req_type = kind;
    b.random_word = word;
    pending_req_q.push_back(b);
  endtask

  // restart-led runs that mostly draw the pool down past empty
  task automatic add_runs(int unsigned n_items, logic [rdwr_pkg::CNT_W-1:0] size);
    int unsigned pushed;
    int unsigned run_len;
    int unsigned r;
    pushed = 0;
    while (pushed < n_items) begin
      if ($urandom_range(9) != 0) begin
        add_req(rdwr_pkg::REQ_RESTART, pick_word());
        pushed++;
      end
      run_len = clamp_pool(size) * 5 / 4 + $urandom_range(1, 4);
      for (int k = 0; k < run_len && pushed < n_items; k++) begin
        r = $urandom_range(99);
        if (r < 88) add_req(rdwr_pkg::REQ_DRAW, pick_word());
        else if (r < 94) add_req(rdwr_pkg::REQ_CANCEL, pick_word());
        else if (r < 97) add_req(REQ_UNKNOWN, pick_word());
        else if (r < 98) add_req(rdwr_pkg::REQ_RESTART, pick_word());
        else add_req(2'($urandom_range(3)), pick_word());
        pushed++;
      end
    end
  endtask

  // wait until every beat is sent and every result has come back
  task automatic settle();
    while (pending_req_q.size() != 0 || in_valid || owed_outcome_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool(logic [rdwr_pkg::CNT_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    pool_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int unsigned mode);
    @(negedge clk);
    case (mode % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 48; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 48; end
      default: begin send_idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // input driver: next beat once the current one is taken
  always @(posedge clk) begin : drive_in
    rdwr_pkg::rdwr_in_t nxt_beat;
    logic nxt_valid;
    nxt_beat = in_beat;
    nxt_valid = in_valid;
    if (rst_n && (!in_valid || in_stall === 1'b0)) begin
      nxt_valid = 1'b0;
      if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_beat = pending_req_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_beat <= nxt_beat;
    in_valid <= nxt_valid;
  end

  // output stall: random, plus long hold-offs on request
  always @(posedge clk) begin : drive_stall
    if (holds_done != holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : watch
    rdwr_pkg::rdwr_out_t want;
    if (rst_n && in_valid && in_stall === 1'b0)
      owed_outcome_q.push_back(draw_outcome(in_beat));
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (owed_outcome_q.size() == 0) begin
        flag_fault("result beat with nothing expected");
      end else begin
        want = owed_outcome_q.pop_front();
        if (out_beat.drawn_value !== want.drawn_value)
          flag_fault($sformatf("drawn_value got %0d want %0d",
                               out_beat.drawn_value, want.drawn_value));
        if (out_beat.pool_empty !== want.pool_empty)
          flag_fault($sformatf("pool_empty got %0b want %0b",
                               out_beat.pool_empty, want.pool_empty));
        if (out_beat.remaining !== want.remaining)
          flag_fault($sformatf("remaining got %0d want %0d",
                               out_beat.remaining, want.remaining));
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    logic [rdwr_pkg::CNT_W-1:0] sizes [11];
    int unsigned counts [11];
    sizes = '{2, 17, 0, 100, 511, 5, 255, 1, 64, 256, 3};
    counts = '{80, 90, 50, 130, 330, 80, 100, 50, 90, 80, 70};
    pool_reg = 9'd256;
    refill_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // full pool after reset: cancel at full, word extremes, unknown code
    set_idling(0);
    add_req(rdwr_pkg::REQ_CANCEL, '0);
    add_req(rdwr_pkg::REQ_DRAW, '0);
    add_req(rdwr_pkg::REQ_DRAW, '1);
    add_req(rdwr_pkg::REQ_CANCEL, '1);
    add_req(REQ_UNKNOWN, '1);
    add_req(rdwr_pkg::REQ_DRAW, '1);
    add_req(rdwr_pkg::REQ_RESTART, '0);

    // new size takes effect only at restart; then empty-pool draws
    write_pool(9'd1);
    set_idling(3);
    add_req(rdwr_pkg::REQ_DRAW, 31'd5);
    add_req(rdwr_pkg::REQ_RESTART, '1);
    add_req(rdwr_pkg::REQ_DRAW, '1);
    add_req(rdwr_pkg::REQ_DRAW, '0);
    add_req(rdwr_pkg::REQ_DRAW, '1);
    add_req(rdwr_pkg::REQ_CANCEL, '0);
    add_req(rdwr_pkg::REQ_CANCEL, '0);
    add_req(REQ_UNKNOWN, '0);
    add_req(rdwr_pkg::REQ_DRAW, '1);

    // random phases over several pool sizes and idling modes
    for (int p = 0; p < 11; p++) begin
      write_pool(sizes[p]);
      set_idling(p);
      add_runs(counts[p], sizes[p]);
      if (p == 1 || p == 6) holds_asked++;
    end

    settle();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
